FILE: rtl/fttf_pkg.sv
package fttf_pkg;

	localparam int MaxFacesDef = 16;
	localparam int FracBitsDef = 16;

	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_ARRAY_W  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ARRAY_H  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_STREAM_W = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_STREAM_H = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PHASE_IN = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PHASE_OUT = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_PAN_LIMIT = 3'd6;

	localparam logic OP_DETECT    = 1'b0;
	localparam logic OP_FRAME_END = 1'b1;

	// restoring divider width: numerators stay below 2^47
	localparam int DivW = 64;

	typedef struct packed {
		logic          start;
		logic [DivW-1:0] num;
		logic [DivW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic [DivW-1:0] quo;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV_L,
		ST_DIV_T,
		ST_DIV_W,
		ST_DIV_H,
		ST_SCAN,
		ST_SQ_X,
		ST_SQ_Y,
		ST_TEST,
		ST_COMMIT,
		ST_FLUSH,
		ST_AGG,
		ST_ASP_A,
		ST_ASP_S,
		ST_CROP_M1,
		ST_CROP_M2,
		ST_CROP_D1,
		ST_CROP_D2,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/face_track_table_framing_core.sv
// face tracking table with framing rectangle
//
// input channel (in_valid / in_stall): opcode 0 is a face detection, opcode 1
// is a frame end. a detection normalises its box with four serial divisions
// and then walks the table looking for a close centre; it gives no result.
// each divide holds the shared restoring divider through start, 64 quotient
// bits and hand-over. the walk passes a free entry in the scan state alone
// and an occupied entry through scan, square x, square y and test. a frame
// end walks the table twice (flush, then bounding box) and, with an active
// face, runs two more divisions for the aspect crop before its result word
// (out_valid / out_stall) appears. one item is worked on at a time:
// in_stall is high from acceptance until the item is finished and, for a frame
// end, until its result word has been taken. a stall on the output simply
// holds the result word. configuration writes (cfg_valid / cfg_ready) are
// always taken. reset clears the valid bits and the overflow flag and restores
// the register defaults; entry payload is not cleared.
module face_track_table_framing_core #(
	parameter int MAX_FACES = fttf_pkg::MaxFacesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] now_ms,
	input  logic [13:0] box_x1,
	input  logic [13:0] box_y1,
	input  logic [13:0] box_x2,
	input  logic [13:0] box_y2,
	input  logic signed [16:0] head_pan,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [16:0] rect_left,
	output logic [16:0] rect_top,
	output logic [16:0] rect_width,
	output logic [16:0] rect_height,
	output logic        overflow
);
	import fttf_pkg::*;

	localparam int FRAC_BITS = FracBitsDef;
	localparam int IdxW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int CntW = $clog2(MAX_FACES + 1);
	localparam int QW   = FRAC_BITS + 2;
	localparam int AspW = 30;
	localparam logic [DivW-1:0] OneQ = DivW'(1) << FRAC_BITS;

	// configuration
	logic [14:0] aw_q, ah_q, sw_q, sh_q;
	logic [15:0] pin_q, pout_q, plim_q;

	// table
	logic [MAX_FACES-1:0] vld_q;
	logic [QW-1:0]  e_l [MAX_FACES];
	logic [QW-1:0]  e_t [MAX_FACES];
	logic [QW-1:0]  e_w [MAX_FACES];
	logic [QW-1:0]  e_h [MAX_FACES];
	logic [31:0]    e_last [MAX_FACES];
	logic [31:0]    e_first [MAX_FACES];
	logic           e_att [MAX_FACES];
	logic           ovf_q;

	// item
	state_t st_q, st_d;
	logic [31:0] now_q;
	logic [13:0] x1_q, y1_q, x2_q, y2_q;
	logic        att_q;
	logic [QW-1:0] l_q, t_q, w_q, h_q;
	logic [CntW-1:0] idx_q;
	logic [IdxW-1:0] idx;
	logic        hit_q;
	logic [IdxW-1:0] slot_q;
	logic        free_ok_q;
	logic [IdxW-1:0] free_q;
	logic [QW:0] dx_q, dy_q;
	logic [2*QW+1:0] sqx_q, sqy_q;
	logic        any_q;
	logic [QW:0] minl_q, mint_q, maxr_q, maxb_q;
	logic [DivW-1:0] a_q, s_q, m1_q, m2_q;
	logic        found_q, ovo_q, outv_q;
	logic [16:0] rl_q, rt_q, rw_q, rh_q;

	div_req_t dreq;
	div_rsp_t drsp;

	fttf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign idx = idx_q[IdxW-1:0];
	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != ST_IDLE) || outv_q;

	function automatic logic [QW-1:0] sat1(input logic [DivW-1:0] v);
		logic [QW-1:0] r;
		r = (v > OneQ) ? QW'(OneQ) : QW'(v);
		return r;
	endfunction

	function automatic logic [DivW-1:0] nz15(input logic [14:0] v);
		logic [DivW-1:0] r;
		r = (v == '0) ? DivW'(1) : DivW'(v);
		return r;
	endfunction

	// pan magnitude and attention at acceptance
	logic [16:0] pan_mag;
	assign pan_mag = head_pan[16] ? 17'(-head_pan) : 17'(head_pan);

	// current entry views
	logic [QW+1:0] cen_n_x, cen_n_y, cen_e_x, cen_e_y;
	assign cen_n_x = {l_q, 1'b0} + (QW+2)'(w_q);
	assign cen_n_y = {t_q, 1'b0} + (QW+2)'(h_q);
	assign cen_e_x = {e_l[idx], 1'b0} + (QW+2)'(e_w[idx]);
	assign cen_e_y = {e_t[idx], 1'b0} + (QW+2)'(e_h[idx]);

	logic [31:0] el_last, el_first;
	assign el_last  = now_q - e_last[idx];
	assign el_first = now_q - e_first[idx];

	logic [QW:0] er, eb;
	assign er = (QW+1)'(e_l[idx]) + (QW+1)'(e_w[idx]);
	assign eb = (QW+1)'(e_t[idx]) + (QW+1)'(e_h[idx]);

	// 25 * (dx^2 + dy^2) < ONE^2
	logic [2*QW+8:0] dist25;
	assign dist25 = ((2*QW+9)'(sqx_q) + (2*QW+9)'(sqy_q)) * (2*QW+9)'(25);

	logic last_idx;
	assign last_idx = (idx_q == CntW'(MAX_FACES - 1));

	logic [DivW-1:0] crop_w, crop_h;
	assign crop_w = DivW'(maxr_q - minl_q);
	assign crop_h = DivW'(maxb_q - mint_q);

	// aspect products are below 2^30
	logic [DivW-1:0] a_n, s_n;
	assign a_n = DivW'(a_q[AspW-1:0]);
	assign s_n = DivW'(s_q[AspW-1:0]);

	always_comb begin
		st_d = st_q;
		dreq = '0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid && !in_stall && !outv_q)
					st_d = (opcode == OP_FRAME_END) ? ST_FLUSH : ST_DIV_L;
			end
			ST_DIV_L, ST_DIV_T, ST_DIV_W, ST_DIV_H: begin
				if (!drsp.busy && !drsp.done) begin
					dreq.start = 1'b1;
					case (st_q)
						ST_DIV_L: begin
							dreq.num = DivW'(x1_q) << FRAC_BITS;
							dreq.den = nz15(aw_q);
						end
						ST_DIV_T: begin
							dreq.num = DivW'(y1_q) << FRAC_BITS;
							dreq.den = nz15(ah_q);
						end
						ST_DIV_W: begin
							dreq.num = (x2_q > x1_q) ? DivW'(x2_q - x1_q) << FRAC_BITS : '0;
							dreq.den = nz15(aw_q);
						end
						default: begin
							dreq.num = (y2_q > y1_q) ? DivW'(y2_q - y1_q) << FRAC_BITS : '0;
							dreq.den = nz15(ah_q);
						end
					endcase
				end
				if (drsp.done) begin
					case (st_q)
						ST_DIV_L: st_d = ST_DIV_T;
						ST_DIV_T: st_d = ST_DIV_W;
						ST_DIV_W: st_d = ST_DIV_H;
						default:  st_d = ST_SCAN;
					endcase
				end
			end
			ST_SCAN: begin
				if (idx_q == CntW'(MAX_FACES)) st_d = ST_COMMIT;
				else if (vld_q[idx]) st_d = ST_SQ_X;
			end
			ST_SQ_X: st_d = ST_SQ_Y;
			ST_SQ_Y: st_d = ST_TEST;
			ST_TEST: begin
				if (dist25 < (2*QW+9)'(OneQ * OneQ)) st_d = ST_COMMIT;
				else st_d = ST_SCAN;
			end
			ST_COMMIT: st_d = ST_IDLE;
			ST_FLUSH: if (last_idx) st_d = ST_AGG;
			ST_AGG: if (last_idx) st_d = ST_ASP_A;
			ST_ASP_A: st_d = ST_ASP_S;
			ST_ASP_S: st_d = any_q ? ST_CROP_M1 : ST_OUT;
			ST_CROP_M1: st_d = ST_CROP_M2;
			ST_CROP_M2: st_d = ST_CROP_D1;
			ST_CROP_D1, ST_CROP_D2: begin
				if (!drsp.busy && !drsp.done) begin
					dreq.start = 1'b1;
					if (a_q < s_q) begin
						if (st_q == ST_CROP_D1) begin
							dreq.num = m1_q;
							dreq.den = a_q;
						end else begin
							dreq.num = m2_q;
							dreq.den = a_q << 1;
						end
					end else begin
						if (st_q == ST_CROP_D1) begin
							dreq.num = m1_q;
							dreq.den = s_q;
						end else begin
							dreq.num = m2_q;
							dreq.den = s_q << 1;
						end
					end
				end
				if (drsp.done) st_d = (st_q == ST_CROP_D1) ? ST_CROP_D2 : ST_OUT;
			end
			ST_OUT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			vld_q  <= '0;
			ovf_q  <= 1'b0;
			outv_q <= 1'b0;
			idx_q  <= '0;
			aw_q   <= 15'd1920;
			ah_q   <= 15'd1080;
			sw_q   <= 15'd1920;
			sh_q   <= 15'd1080;
			pin_q  <= 16'd3000;
			pout_q <= 16'd3000;
			plim_q <= 16'd7680;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ARRAY_W:   aw_q   <= cfg_data[14:0];
					REG_ARRAY_H:   ah_q   <= cfg_data[14:0];
					REG_STREAM_W:  sw_q   <= cfg_data[14:0];
					REG_STREAM_H:  sh_q   <= cfg_data[14:0];
					REG_PHASE_IN:  pin_q  <= cfg_data;
					REG_PHASE_OUT: pout_q <= cfg_data;
					REG_PAN_LIMIT: plim_q <= cfg_data;
					default: ;
				endcase
			end
			if (outv_q && !out_stall) outv_q <= 1'b0;
			case (st_q)
				ST_IDLE: idx_q <= '0;
				ST_SCAN: if (!vld_q[idx] && idx_q != CntW'(MAX_FACES)) idx_q <= idx_q + 1'b1;
				ST_TEST: if (st_d == ST_SCAN) idx_q <= idx_q + 1'b1;
				ST_COMMIT: begin
					if (hit_q) vld_q[slot_q] <= 1'b1;
					else if (free_ok_q) vld_q[free_q] <= 1'b1;
					else ovf_q <= 1'b1;
				end
				ST_FLUSH: begin
					if (vld_q[idx] && el_last > 32'(pout_q)) vld_q[idx] <= 1'b0;
					idx_q <= last_idx ? '0 : idx_q + 1'b1;
				end
				ST_AGG: idx_q <= idx_q + 1'b1;
				ST_OUT: begin
					outv_q <= 1'b1;
					ovf_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				now_q <= now_ms;
				x1_q  <= box_x1;
				y1_q  <= box_y1;
				x2_q  <= box_x2;
				y2_q  <= box_y2;
				att_q <= pan_mag < 17'(plim_q);
				hit_q <= 1'b0;
				free_ok_q <= 1'b0;
				free_q <= '0;
				slot_q <= '0;
				any_q <= 1'b0;
				minl_q <= (QW+1)'(OneQ);
				mint_q <= (QW+1)'(OneQ);
				maxr_q <= '0;
				maxb_q <= '0;
			end
			ST_DIV_L: if (drsp.done) l_q <= sat1(drsp.quo);
			ST_DIV_T: if (drsp.done) t_q <= sat1(drsp.quo);
			ST_DIV_W: if (drsp.done) w_q <= sat1(drsp.quo);
			ST_DIV_H: if (drsp.done) h_q <= sat1(drsp.quo);
			ST_SCAN: begin
				if (idx_q != CntW'(MAX_FACES) && !vld_q[idx] && !free_ok_q) begin
					free_ok_q <= 1'b1;
					free_q <= idx;
				end
				dx_q <= (cen_n_x > cen_e_x) ? (QW+1)'(cen_n_x - cen_e_x)
				                            : (QW+1)'(cen_e_x - cen_n_x);
				dy_q <= (cen_n_y > cen_e_y) ? (QW+1)'(cen_n_y - cen_e_y)
				                            : (QW+1)'(cen_e_y - cen_n_y);
			end
			ST_SQ_X: sqx_q <= (2*QW+2)'(dx_q) * (2*QW+2)'(dx_q);
			ST_SQ_Y: sqy_q <= (2*QW+2)'(dy_q) * (2*QW+2)'(dy_q);
			ST_TEST: begin
				if (st_d == ST_COMMIT) begin
					hit_q  <= 1'b1;
					slot_q <= idx;
				end
			end
			ST_COMMIT: begin
				if (hit_q || free_ok_q) begin
					e_l[hit_q ? slot_q : free_q]    <= l_q;
					e_t[hit_q ? slot_q : free_q]    <= t_q;
					e_w[hit_q ? slot_q : free_q]    <= w_q;
					e_h[hit_q ? slot_q : free_q]    <= h_q;
					e_last[hit_q ? slot_q : free_q] <= now_q;
					e_att[hit_q ? slot_q : free_q]  <= att_q;
					if (!hit_q) e_first[free_q] <= now_q;
				end
			end
			ST_AGG: begin
				if (vld_q[idx] && e_att[idx] && el_first > 32'(pin_q)) begin
					any_q <= 1'b1;
					if ((QW+1)'(e_l[idx]) < minl_q) minl_q <= (QW+1)'(e_l[idx]);
					if ((QW+1)'(e_t[idx]) < mint_q) mint_q <= (QW+1)'(e_t[idx]);
					if (er > maxr_q) maxr_q <= er;
					if (eb > maxb_q) maxb_q <= eb;
				end
			end
			ST_ASP_A: a_q <= nz15(aw_q) * nz15(sh_q);
			ST_ASP_S: s_q <= nz15(sw_q) * nz15(ah_q);
			ST_CROP_M1: m1_q <= (a_q < s_q) ? DivW'(crop_h[QW:0]) * s_n
			                                : DivW'(crop_w[QW:0]) * a_n;
			ST_CROP_M2: begin
				if (a_q < s_q)
					m2_q <= ((DivW'(mint_q) * s_n) << 1) > (OneQ * (s_q - a_q))
					        ? ((DivW'(mint_q) * s_n) << 1) - OneQ * (s_q - a_q) : '0;
				else
					m2_q <= ((DivW'(minl_q) * a_n) << 1) > (OneQ * (a_q - s_q))
					        ? ((DivW'(minl_q) * a_n) << 1) - OneQ * (a_q - s_q) : '0;
			end
			ST_CROP_D1: if (drsp.done) m1_q <= drsp.quo;
			ST_CROP_D2: if (drsp.done) m2_q <= drsp.quo;
			ST_OUT: begin
				found_q <= any_q;
				ovo_q   <= ovf_q;
				if (!any_q) begin
					rl_q <= '0;
					rt_q <= '0;
					rw_q <= '0;
					rh_q <= '0;
				end else if (a_q < s_q) begin
					rl_q <= 17'(sat1(DivW'(minl_q)));
					rt_q <= 17'(sat1(m2_q));
					rw_q <= 17'(sat1(crop_w));
					rh_q <= 17'(sat1(m1_q));
				end else begin
					rl_q <= 17'(sat1(m2_q));
					rt_q <= 17'(sat1(DivW'(mint_q)));
					rw_q <= 17'(sat1(m1_q));
					rh_q <= 17'(sat1(crop_h));
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = outv_q;
	assign found       = found_q;
	assign rect_left   = rl_q;
	assign rect_top    = rt_q;
	assign rect_width  = rw_q;
	assign rect_height = rh_q;
	assign overflow    = ovo_q;
endmodule

FILE: rtl/fttf_div.sv
module fttf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fttf_pkg::div_req_t req,
	output fttf_pkg::div_rsp_t rsp
);
	import fttf_pkg::*;

	localparam int CntW = $clog2(DivW + 1);

	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] quo_q;
	logic [DivW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DivW:0]   trial;
	logic [DivW:0]   shifted;

	// one quotient bit per cycle, msb first
	assign shifted = {rem_q, quo_q[DivW-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[DivW]) begin
				rem_q <= trial[DivW-1:0];
				quo_q <= {quo_q[DivW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DivW-1:0];
				quo_q <= {quo_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

FILE: rtl/fttf_checker.sv
module fttf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic found,
	input logic [16:0] rect_width,
	input logic [16:0] rect_height,
	input logic [16:0] rect_left
);
	// result word stays valid and its width holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rect_width))
		else $error("result word changed under stall");

	// no accept while a result word is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("item taken with result pending");

	// accepted item blocks the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("back-to-back accept");

	// no face gives zero width, height and left
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> rect_width == '0 && rect_height == '0 && rect_left == '0)
		else $error("rectangle not zero without a face");
endmodule

bind face_track_table_framing_core fttf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .found(found),
	.rect_width(rect_width), .rect_height(rect_height), .rect_left(rect_left)
);
